// ===== rtl/lrb_pkg.sv =====
// Shared types, codes and reset constants of the link reconnect backoff controller.
package lrb_pkg;

    // Widths of the item fields and configuration registers
    localparam int unsigned TimeW     = 32;
    localparam int unsigned BaseW     = 16;
    localparam int unsigned FailW     = 4;
    localparam int unsigned LostW     = 16;
    localparam int unsigned CfgIndexW = 2;
    localparam int unsigned CfgDataW  = 32;

    // Saturation limits
    localparam logic [FailW-1:0] FailMax = '1;
    localparam logic [LostW-1:0] LostMax = '1;

    // Configuration reset values
    localparam logic [TimeW-1:0] ConnectTimeoutReset = 32'd15000;
    localparam logic [BaseW-1:0] BackoffBaseReset    = 16'd1000;
    localparam logic [TimeW-1:0] BackoffMaxReset     = 32'd60000;
    localparam logic [FailW-1:0] MaxFailuresReset    = 4'd3;

    // Item kinds
    typedef enum logic [1:0] {
        MODE_POLL      = 2'd0,
        MODE_CREDS     = 2'd1,
        MODE_RECONNECT = 2'd2,
        MODE_FORGET    = 2'd3
    } mode_t;

    // Link states
    typedef enum logic [1:0] {
        LS_DISC       = 2'd0,
        LS_CONNECTING = 2'd1,
        LS_CONNECTED  = 2'd2,
        LS_AP         = 2'd3
    } link_state_t;

    // Configuration register indexes
    typedef enum logic [CfgIndexW-1:0] {
        CFG_CONNECT_TIMEOUT = 2'd0,
        CFG_BACKOFF_BASE    = 2'd1,
        CFG_BACKOFF_MAX     = 2'd2,
        CFG_MAX_FAILURES    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [TimeW-1:0] connect_timeout_ms;
        logic [BaseW-1:0] backoff_base_ms;
        logic [TimeW-1:0] backoff_max_ms;
        logic [FailW-1:0] max_failures;
    } cfg_t;

    typedef struct packed {
        mode_t            mode;
        logic [TimeW-1:0] now_ms;
        logic             link_up;
        logic             same_credentials;
        logic             credentials_nonempty;
    } in_item_t;

    typedef struct packed {
        link_state_t      link_state;
        logic             start_connect;
        logic             start_access_point;
        logic             drop_fallback;
        logic             disconnect_radio;
        logic [FailW-1:0] failure_count;
        logic [LostW-1:0] lost_link_count;
    } result_t;

endpackage

// ===== rtl/lrb_cfg_regs.sv =====
// Configuration register bank of the link reconnect backoff controller.
module lrb_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [lrb_pkg::CfgIndexW-1:0]   cfg_addr,
    input  logic [lrb_pkg::CfgDataW-1:0]    cfg_wr_data,
    output lrb_pkg::cfg_t                   cfg
);

    lrb_pkg::cfg_t cfg_reg;
    lrb_pkg::cfg_t cfg_next;

    // Decode the write into the addressed register
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (lrb_pkg::cfg_index_t'(cfg_addr))
                lrb_pkg::CFG_CONNECT_TIMEOUT:
                    cfg_next.connect_timeout_ms = cfg_wr_data[lrb_pkg::TimeW-1:0];
                lrb_pkg::CFG_BACKOFF_BASE:
                    cfg_next.backoff_base_ms = cfg_wr_data[lrb_pkg::BaseW-1:0];
                lrb_pkg::CFG_BACKOFF_MAX:
                    cfg_next.backoff_max_ms = cfg_wr_data[lrb_pkg::TimeW-1:0];
                lrb_pkg::CFG_MAX_FAILURES:
                    cfg_next.max_failures = cfg_wr_data[lrb_pkg::FailW-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the settings, load defaults on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.connect_timeout_ms <= lrb_pkg::ConnectTimeoutReset;
            cfg_reg.backoff_base_ms    <= lrb_pkg::BackoffBaseReset;
            cfg_reg.backoff_max_ms     <= lrb_pkg::BackoffMaxReset;
            cfg_reg.max_failures       <= lrb_pkg::MaxFailuresReset;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/lrb_core.sv =====
// Link state machine with backoff timing: state registers and per-item update logic.
module lrb_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_fire,
    input  lrb_pkg::in_item_t item,
    input  lrb_pkg::cfg_t     cfg,
    output lrb_pkg::result_t  result
);

    lrb_pkg::link_state_t         state_reg, state_next;
    logic                         creds_reg, creds_next;
    logic                         pending_reg, pending_next;
    logic [lrb_pkg::FailW-1:0]    failures_reg, failures_next;
    logic [lrb_pkg::TimeW-1:0]    attempt_start_reg, attempt_start_next;
    logic [lrb_pkg::TimeW-1:0]    last_attempt_reg, last_attempt_next;
    logic [lrb_pkg::LostW-1:0]    lost_reg, lost_next;

    logic                         is_poll;
    logic                         do_action;
    logic                         poll_sm;
    logic                         active;
    logic                         creds_ignored;
    logic [lrb_pkg::FailW-1:0]    failures_inc;
    logic [lrb_pkg::FailW-1:0]    shift_amt;
    logic [lrb_pkg::TimeW-1:0]    shifted_base;
    logic [lrb_pkg::TimeW-1:0]    retry_delay;
    logic [lrb_pkg::TimeW-1:0]    since_start;
    logic [lrb_pkg::TimeW-1:0]    since_last;
    logic                         conn_up;
    logic                         conn_timeout;
    logic                         fail_to_ap;
    logic                         link_lost;
    logic                         retry_go;

    // Decode the item against the current state
    assign is_poll   = (item.mode == lrb_pkg::MODE_POLL);
    assign do_action = is_poll && pending_reg;
    assign poll_sm   = is_poll && !pending_reg;
    assign active    = (state_reg == lrb_pkg::LS_CONNECTING) ||
                       (state_reg == lrb_pkg::LS_CONNECTED);
    assign creds_ignored = creds_reg && item.same_credentials && active;

    // Saturating failure increment
    assign failures_inc = (failures_reg < lrb_pkg::FailMax) ?
                          failures_reg + lrb_pkg::FailW'(1) : failures_reg;

    // Retry delay: zero with no failures, else base shifted by failures-1, capped at the maximum
    assign shift_amt    = failures_reg - lrb_pkg::FailW'(1);
    assign shifted_base = lrb_pkg::TimeW'(cfg.backoff_base_ms) << shift_amt;
    always_comb begin
        if (failures_reg == '0) begin
            retry_delay = '0;
        end else if (shifted_base > cfg.backoff_max_ms) begin
            retry_delay = cfg.backoff_max_ms;
        end else begin
            retry_delay = shifted_base;
        end
    end

    // Elapsed times, modulo 2^32
    assign since_start = item.now_ms - attempt_start_reg;
    assign since_last  = item.now_ms - last_attempt_reg;

    // Poll events of the state machine
    assign conn_up      = poll_sm && (state_reg == lrb_pkg::LS_CONNECTING) && item.link_up;
    assign conn_timeout = poll_sm && (state_reg == lrb_pkg::LS_CONNECTING) && !item.link_up &&
                          (since_start >= cfg.connect_timeout_ms);
    assign fail_to_ap   = conn_timeout && (failures_inc >= cfg.max_failures);
    assign link_lost    = poll_sm && (state_reg == lrb_pkg::LS_CONNECTED) && !item.link_up;
    assign retry_go     = poll_sm && (state_reg == lrb_pkg::LS_DISC) && creds_reg &&
                          (since_last >= retry_delay);

    // Next state and flags
    always_comb begin
        state_next         = state_reg;
        creds_next         = creds_reg;
        pending_next       = pending_reg;
        failures_next      = failures_reg;
        attempt_start_next = attempt_start_reg;
        last_attempt_next  = last_attempt_reg;
        lost_next          = lost_reg;
        unique case (item.mode)
            lrb_pkg::MODE_CREDS: begin
                if (!creds_ignored) begin
                    creds_next    = item.credentials_nonempty;
                    failures_next = '0;
                    pending_next  = 1'b1;
                end
            end
            lrb_pkg::MODE_RECONNECT: begin
                failures_next = '0;
                pending_next  = 1'b1;
            end
            lrb_pkg::MODE_FORGET: begin
                creds_next    = 1'b0;
                failures_next = '0;
                pending_next  = 1'b1;
            end
            lrb_pkg::MODE_POLL: begin
                priority if (do_action) begin
                    pending_next = 1'b0;
                    if (creds_reg) begin
                        state_next         = lrb_pkg::LS_CONNECTING;
                        attempt_start_next = item.now_ms;
                        last_attempt_next  = item.now_ms;
                    end else begin
                        state_next = lrb_pkg::LS_AP;
                    end
                end else if (conn_up) begin
                    state_next    = lrb_pkg::LS_CONNECTED;
                    lost_next     = '0;
                    failures_next = '0;
                end else if (conn_timeout) begin
                    failures_next = failures_inc;
                    if (fail_to_ap) begin
                        state_next = lrb_pkg::LS_AP;
                    end else begin
                        state_next        = lrb_pkg::LS_DISC;
                        last_attempt_next = item.now_ms;
                    end
                end else if (link_lost) begin
                    state_next        = lrb_pkg::LS_DISC;
                    lost_next         = (lost_reg < lrb_pkg::LostMax) ?
                                        lost_reg + lrb_pkg::LostW'(1) : lost_reg;
                    last_attempt_next = item.now_ms;
                end else if (retry_go) begin
                    state_next         = lrb_pkg::LS_CONNECTING;
                    attempt_start_next = item.now_ms;
                    last_attempt_next  = item.now_ms;
                end else begin
                    state_next = state_reg;
                end
            end
            default: state_next = state_reg;
        endcase
    end

    // Result fields and commands
    always_comb begin
        result.link_state         = state_next;
        result.start_connect      = (do_action && creds_reg) || retry_go;
        result.start_access_point = (do_action && !creds_reg) || fail_to_ap;
        result.drop_fallback      = conn_up;
        result.disconnect_radio   = (item.mode == lrb_pkg::MODE_FORGET);
        result.failure_count      = failures_next;
        result.lost_link_count    = lost_next;
    end

    // Advance the state on each processed item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= lrb_pkg::LS_DISC;
            creds_reg         <= 1'b0;
            pending_reg       <= 1'b0;
            failures_reg      <= '0;
            attempt_start_reg <= '0;
            last_attempt_reg  <= '0;
            lost_reg          <= '0;
        end else if (item_fire) begin
            state_reg         <= state_next;
            creds_reg         <= creds_next;
            pending_reg       <= pending_next;
            failures_reg      <= failures_next;
            attempt_start_reg <= attempt_start_next;
            last_attempt_reg  <= last_attempt_next;
            lost_reg          <= lost_next;
        end
    end

endmodule

// ===== rtl/link_reconnect_backoff_fsm_unit.sv =====
// Link reconnect controller: one result item for every poll or request item, in order.
// Each accepted item lands in an input register, is evaluated against the link state
// in combinational logic, and its result is held in an output register until taken,
// so the block accepts one item per clock while the output register is free or being
// drained; a result passes through the input and then the output register before it
// is presented. The state update (shifted backoff delay, elapsed-time subtract and
// compare) is combinational; both sides may stall freely.
// Configuration writes take effect at the next clock and belong in idle periods.
module link_reconnect_backoff_fsm_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port
    input  logic                          cfg_wr_en,
    input  logic [lrb_pkg::CfgIndexW-1:0] cfg_addr,
    input  logic [lrb_pkg::CfgDataW-1:0]  cfg_wr_data,
    // Input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] now_ms, [32] link_up, [33] same_credentials,
    // [34] credentials_nonempty, [39:35] zero
    input  logic [39:0]                   s_tdata,
    // [1:0] mode
    input  logic [1:0]                    s_tuser,
    // Result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [1:0] link_state, [2] start_connect, [3] start_access_point, [4] drop_fallback,
    // [5] disconnect_radio, [9:6] failure_count, [25:10] lost_link_count, [31:26] zero
    output logic [31:0]                   m_tdata
);

    lrb_pkg::cfg_t     cfg;
    lrb_pkg::in_item_t in_item_reg, in_item_next;
    logic              in_valid_reg, in_valid_next;
    lrb_pkg::result_t  core_result;
    lrb_pkg::result_t  out_reg;
    logic              out_valid_reg, out_valid_next;
    logic              s_fire;
    logic              advance;

    lrb_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    lrb_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_fire (advance),
        .item      (in_item_reg),
        .cfg       (cfg),
        .result    (core_result)
    );

    // Handshake: advance when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    // Unpack the incoming item
    always_comb begin
        in_item_next.mode                 = lrb_pkg::mode_t'(s_tuser);
        in_item_next.now_ms               = s_tdata[31:0];
        in_item_next.link_up              = s_tdata[32];
        in_item_next.same_credentials     = s_tdata[33];
        in_item_next.credentials_nonempty = s_tdata[34];
    end

    assign in_valid_next  = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // Control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= in_item_next;
        end
        if (advance) begin
            out_reg <= core_result;
        end
    end

    // Pack the result item
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0,
                       out_reg.lost_link_count,
                       out_reg.failure_count,
                       out_reg.disconnect_radio,
                       out_reg.drop_fallback,
                       out_reg.start_access_point,
                       out_reg.start_connect,
                       out_reg.link_state};

    // A result never starts a station attempt and the access point together
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_reg.start_connect && out_reg.start_access_point))
        else $error("start_connect and start_access_point in one result");

    // A started attempt leaves the link connecting
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.start_connect |->
            out_reg.link_state == lrb_pkg::LS_CONNECTING)
        else $error("start_connect without connecting state");

    // A confirmed connection clears both counters
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.drop_fallback |->
            (out_reg.failure_count == '0) && (out_reg.lost_link_count == '0) &&
            (out_reg.link_state == lrb_pkg::LS_CONNECTED))
        else $error("drop_fallback with stale counters or wrong state");

    // A waiting item is not lost while the result register is blocked
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input item dropped under back-pressure");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the link reconnect backoff controller.
module tb;
    import lrb_pkg::*;

    localparam int unsigned IdleLimit  = 3000;
    localparam int unsigned LongHoldCy = 400;

    // Clock, reset and block ports
    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CfgIndexW-1:0] cfg_addr    = '0;
    logic [CfgDataW-1:0]  cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [39:0]          s_tdata     = '0;
    logic [1:0]           s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [31:0]          m_tdata;

    link_reconnect_backoff_fsm_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Stimulus and expectation stores
    in_item_t pending_items[$];
    in_item_t offered_item;
    result_t  expected_status[$];

    // Shadow of the controller state and its settings
    cfg_t             shadow_cfg;
    link_state_t      shadow_link;
    logic             shadow_creds;
    logic             shadow_pending;
    logic [FailW-1:0] shadow_fails;
    logic [TimeW-1:0] shadow_attempt_start;
    logic [TimeW-1:0] shadow_last_attempt;
    logic [LostW-1:0] shadow_lost;

    // Run bookkeeping
    bit          traffic_gaps = 1'b0;
    bit          long_hold_req = 1'b0;
    bit          long_hold_taken = 1'b0;
    int unsigned src_gap = 0;
    int unsigned sink_hold = 0;
    int unsigned idle_cycles = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned connect_starts = 0;
    int unsigned ap_fallbacks = 0;
    int unsigned settings_used = 1;
    int unsigned errors = 0;
    logic [TimeW-1:0] clock_ms = '0;
    bit          good_radio = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Work out the status item that one accepted item produces, and advance the shadow
    function automatic result_t step_link_fsm(in_item_t it);
        result_t     r;
        logic [63:0] wide_delay;
        logic        active;
        r = '0;
        active = (shadow_link == LS_CONNECTING) || (shadow_link == LS_CONNECTED);
        case (it.mode)
            MODE_CREDS: begin
                // identical credentials while an attempt or link is up change nothing
                if (!(shadow_creds && it.same_credentials && active)) begin
                    shadow_creds   = it.credentials_nonempty;
                    shadow_fails   = '0;
                    shadow_pending = 1'b1;
                end
            end
            MODE_RECONNECT: begin
                shadow_fails   = '0;
                shadow_pending = 1'b1;
            end
            MODE_FORGET: begin
                shadow_creds       = 1'b0;
                shadow_fails       = '0;
                r.disconnect_radio = 1'b1;
                shadow_pending     = 1'b1;
            end
            MODE_POLL: begin
                if (shadow_pending) begin
                    shadow_pending = 1'b0;
                    if (shadow_creds) begin
                        shadow_link          = LS_CONNECTING;
                        shadow_attempt_start = it.now_ms;
                        shadow_last_attempt  = it.now_ms;
                        r.start_connect      = 1'b1;
                    end else begin
                        shadow_link          = LS_AP;
                        r.start_access_point = 1'b1;
                    end
                end else begin
                    case (shadow_link)
                        LS_CONNECTING: begin
                            if (it.link_up) begin
                                shadow_link     = LS_CONNECTED;
                                shadow_lost     = '0;
                                shadow_fails    = '0;
                                r.drop_fallback = 1'b1;
                            end else if (TimeW'(it.now_ms - shadow_attempt_start)
                                         >= shadow_cfg.connect_timeout_ms) begin
                                if (shadow_fails != FailMax) shadow_fails++;
                                if (shadow_fails >= shadow_cfg.max_failures) begin
                                    shadow_link          = LS_AP;
                                    r.start_access_point = 1'b1;
                                end else begin
                                    shadow_link         = LS_DISC;
                                    shadow_last_attempt = it.now_ms;
                                end
                            end
                        end
                        LS_CONNECTED: begin
                            if (!it.link_up) begin
                                shadow_link = LS_DISC;
                                if (shadow_lost != LostMax) shadow_lost++;
                                shadow_last_attempt = it.now_ms;
                            end
                        end
                        LS_DISC: begin
                            // exponential backoff, capped, zero when no failure yet
                            if (shadow_fails == '0) begin
                                wide_delay = '0;
                            end else begin
                                wide_delay = {48'b0, shadow_cfg.backoff_base_ms}
                                             << (shadow_fails - 1'b1);
                            end
                            if (wide_delay > {32'b0, shadow_cfg.backoff_max_ms}) begin
                                wide_delay = {32'b0, shadow_cfg.backoff_max_ms};
                            end
                            if (shadow_creds &&
                                {32'b0, TimeW'(it.now_ms - shadow_last_attempt)}
                                >= wide_delay) begin
                                shadow_link          = LS_CONNECTING;
                                shadow_attempt_start = it.now_ms;
                                shadow_last_attempt  = it.now_ms;
                                r.start_connect      = 1'b1;
                            end
                        end
                        default: begin
                            // access point: wait for a request
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
        r.link_state      = shadow_link;
        r.failure_count   = shadow_fails;
        r.lost_link_count = shadow_lost;
        if (r.start_connect) connect_starts++;
        if (r.start_access_point) ap_fallbacks++;
        return r;
    endfunction

    // Compare one field of a status item
    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    // Driver: offer pending items, hold them until taken, insert random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_status.insert(expected_status.size(), step_link_fsm(offered_item));
                items_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (traffic_gaps && pending_items.size() > 0 &&
                             $urandom_range(0, 9) == 0) begin
                    src_gap = $urandom_range(0, 10);
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    offered_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b0, offered_item.credentials_nonempty,
                                 offered_item.same_credentials, offered_item.link_up,
                                 offered_item.now_ms};
                    s_tuser  <= offered_item.mode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: take status items, check them, and stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_status.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected status item, expected none, actual %0h",
                             $time, m_tdata);
                end else begin
                    result_t e;
                    e = expected_status.pop_front();
                    check_field("link_state", 32'(e.link_state), 32'(m_tdata[1:0]));
                    check_field("start_connect", 32'(e.start_connect), 32'(m_tdata[2]));
                    check_field("start_access_point", 32'(e.start_access_point),
                                32'(m_tdata[3]));
                    check_field("drop_fallback", 32'(e.drop_fallback), 32'(m_tdata[4]));
                    check_field("disconnect_radio", 32'(e.disconnect_radio),
                                32'(m_tdata[5]));
                    check_field("failure_count", 32'(e.failure_count), 32'(m_tdata[9:6]));
                    check_field("lost_link_count", 32'(e.lost_link_count),
                                32'(m_tdata[25:10]));
                end
            end
            if (long_hold_req && !long_hold_taken) begin
                long_hold_taken = 1'b1;
                sink_hold = LongHoldCy;
                m_tready <= 1'b0;
            end else if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else if (traffic_gaps && $urandom_range(0, 9) == 0) begin
                sink_hold = $urandom_range(0, 10);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if no item moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
                $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Write one register and mirror it in the shadow settings
    task automatic write_reg(cfg_index_t idx, logic [CfgDataW-1:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        case (idx)
            CFG_CONNECT_TIMEOUT: shadow_cfg.connect_timeout_ms = val;
            CFG_BACKOFF_BASE:    shadow_cfg.backoff_base_ms    = val[BaseW-1:0];
            CFG_BACKOFF_MAX:     shadow_cfg.backoff_max_ms     = val;
            default:             shadow_cfg.max_failures       = val[FailW-1:0];
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_regs(logic [31:0] tmo, logic [31:0] base, logic [31:0] cap,
                            logic [31:0] maxf);
        write_reg(CFG_CONNECT_TIMEOUT, tmo);
        write_reg(CFG_BACKOFF_BASE, base);
        write_reg(CFG_BACKOFF_MAX, cap);
        write_reg(CFG_MAX_FAILURES, maxf);
        settings_used++;
    endtask

    // Wait until every item is accepted and every status item checked, then let the pipe settle
    task automatic wait_idle();
        while (pending_items.size() > 0 || s_tvalid || expected_status.size() > 0) begin
            @(negedge aclk);
        end
        repeat (6) @(negedge aclk);
    endtask

    task automatic push_item(mode_t m, logic [TimeW-1:0] t, bit up, bit same, bit named);
        in_item_t it;
        it.mode                 = m;
        it.now_ms               = t;
        it.link_up              = up;
        it.same_credentials     = same;
        it.credentials_nonempty = named;
        pending_items.insert(pending_items.size(), it);
    endtask

    // Random traffic: mostly polls with advancing time, link quality drifting in runs
    task automatic gen_traffic(int n, int unsigned step);
        in_item_t    it;
        int unsigned pick;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) good_radio = !good_radio;
            if ($urandom_range(0, 24) == 0) clock_ms = $urandom;
            else clock_ms += $urandom_range(0, step);
            pick = $urandom_range(0, 99);
            if (pick < 78)      it.mode = MODE_POLL;
            else if (pick < 86) it.mode = MODE_CREDS;
            else if (pick < 93) it.mode = MODE_RECONNECT;
            else                it.mode = MODE_FORGET;
            it.now_ms               = clock_ms;
            it.link_up              = good_radio ? ($urandom_range(0, 9) != 0)
                                                 : ($urandom_range(0, 9) == 0);
            it.same_credentials     = 1'($urandom_range(0, 1));
            it.credentials_nonempty = ($urandom_range(0, 6) != 0);
            pending_items.insert(pending_items.size(), it);
        end
    endtask

    initial begin
        shadow_cfg.connect_timeout_ms = ConnectTimeoutReset;
        shadow_cfg.backoff_base_ms    = BackoffBaseReset;
        shadow_cfg.backoff_max_ms     = BackoffMaxReset;
        shadow_cfg.max_failures       = MaxFailuresReset;
        shadow_link          = LS_DISC;
        shadow_creds         = 1'b0;
        shadow_pending       = 1'b0;
        shadow_fails         = '0;
        shadow_attempt_start = '0;
        shadow_last_attempt  = '0;
        shadow_lost          = '0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed walk through the controller at its reset settings
        push_item(MODE_POLL, 32'd0, 1'b0, 1'b0, 1'b0);
        push_item(MODE_FORGET, 32'd0, 1'b0, 1'b0, 1'b0);
        push_item(MODE_POLL, 32'd10, 1'b0, 1'b0, 1'b0);
        push_item(MODE_POLL, 32'd20, 1'b1, 1'b0, 1'b0);
        push_item(MODE_CREDS, 32'd25, 1'b0, 1'b0, 1'b0);
        push_item(MODE_POLL, 32'd30, 1'b0, 1'b0, 1'b0);
        push_item(MODE_CREDS, 32'd40, 1'b0, 1'b0, 1'b1);
        push_item(MODE_POLL, 32'd100, 1'b0, 1'b0, 1'b0);
        push_item(MODE_CREDS, 32'd150, 1'b0, 1'b1, 1'b1);
        push_item(MODE_POLL, 32'd200, 1'b1, 1'b0, 1'b0);
        push_item(MODE_CREDS, 32'd250, 1'b1, 1'b1, 1'b0);
        push_item(MODE_POLL, 32'd300, 1'b0, 1'b0, 1'b0);
        push_item(MODE_POLL, 32'd300, 1'b0, 1'b0, 1'b0);
        push_item(MODE_POLL, 32'd15300, 1'b0, 1'b0, 1'b0);
        push_item(MODE_POLL, 32'd15800, 1'b0, 1'b0, 1'b0);
        push_item(MODE_POLL, 32'd16300, 1'b0, 1'b0, 1'b0);
        push_item(MODE_POLL, 32'd31300, 1'b0, 1'b0, 1'b0);
        push_item(MODE_POLL, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        // elapsed time wraps through zero to reach the third timeout
        push_item(MODE_POLL, 32'd14999, 1'b0, 1'b0, 1'b0);
        push_item(MODE_POLL, 32'd20000, 1'b1, 1'b1, 1'b1);
        push_item(MODE_RECONNECT, 32'd20500, 1'b1, 1'b1, 1'b1);
        push_item(MODE_POLL, 32'd21000, 1'b1, 1'b1, 1'b1);
        push_item(MODE_POLL, 32'd21001, 1'b1, 1'b1, 1'b1);
        push_item(MODE_POLL, 32'd21002, 1'b1, 1'b1, 1'b1);
        clock_ms = 32'd21002;
        wait_idle();

        // Reset settings, random traffic, with one long receiver stall
        traffic_gaps = 1'b1;
        gen_traffic(250, 3000);
        long_hold_req = 1'b1;
        wait_idle();

        // Smallest legal settings
        set_regs(32'd1, 32'd1, 32'd1, 32'd1);
        gen_traffic(200, 3);
        wait_idle();

        // All zero: instant timeouts, no backoff, first failure opens the access point
        set_regs(32'd0, 32'hFFFF_0000, 32'd0, 32'hFFFF_FFF0);
        gen_traffic(150, 3);
        wait_idle();

        // Short timeout, deep backoff with many allowed failures
        set_regs(32'd200, 32'd50, 32'd5000, 32'd15);
        gen_traffic(300, 400);
        wait_idle();

        // Largest settings
        set_regs(32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0000_000F);
        gen_traffic(150, 1000);
        wait_idle();

        // Random settings, no idling on either side
        set_regs($urandom_range(1, 3000), $urandom, $urandom_range(0, 100000), $urandom);
        traffic_gaps = 1'b0;
        gen_traffic(300, 2000);
        wait_idle();

        repeat (8) @(posedge aclk);
        $display("Checked %0d status items for %0d input items over %0d register settings;",
                 results_seen, items_sent, settings_used);
        $display("saw %0d connect attempts and %0d access point fallbacks.",
                 connect_starts, ap_fallbacks);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
